@@ sv/fbfa_pkg.sv @@
// Shared types and constants of the best-fit block allocator.
package fbfa_pkg;

    localparam int BLOCKS = 64;
    localparam int IDX_W  = 6;
    localparam int LEN_W  = 7;
    localparam int NEED_W = 20;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_TRIM  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_NOTRIM  = 2'd3;

    localparam logic REG_HEAP_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]  action;
        logic [18:0] size_bytes;
        logic [5:0]  block_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] start_index;
        logic [5:0] heap_bottom;
    } result_t;

    typedef struct packed {
        logic push;
        logic remove;
        logic rotate;
    } lop_t;

endpackage

@@ sv/fbfa_cell.sv @@
// One cell of the free-list chain: holds one free run start.
module fbfa_cell
    import fbfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lop_t             op,
    input  logic [IDX_W-1:0] key,
    input  logic [IDX_W-1:0] prev_val,
    input  logic             prev_vld,
    input  logic [IDX_W-1:0] nxt_val,
    input  logic             nxt_vld,
    input  logic             hit_in,
    output logic [IDX_W-1:0] val,
    output logic             vld,
    output logic             hit_out
);

    logic [IDX_W-1:0] val_reg;
    logic             vld_reg;
    logic             take_next;

    assign hit_out   = hit_in | (vld_reg & (val_reg == key));
    assign take_next = op.rotate | (op.remove & hit_out);
    assign val       = val_reg;
    assign vld       = vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (op.push)
        begin
            vld_reg <= prev_vld;
        end
        else if (take_next)
        begin
            vld_reg <= nxt_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            val_reg <= prev_val;
        end
        else if (take_next)
        begin
            val_reg <= nxt_val;
        end
    end

endmodule

@@ sv/fbfa_list.sv @@
// Free list as a chain of cells with push at head, remove and rotate.
module fbfa_list
    import fbfa_pkg::*;
#(
    parameter int FREE_RUNS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lop_t             op_in,
    input  logic [IDX_W-1:0] key,
    output logic [IDX_W-1:0] head_val,
    output logic             head_vld,
    output logic             full
);

    localparam int CNT_W = $clog2(FREE_RUNS + 1);

    logic [IDX_W-1:0] val_w [FREE_RUNS];
    logic             vld_w [FREE_RUNS];
    logic             hit_w [FREE_RUNS+1];
    logic [CNT_W-1:0] cnt_reg;
    lop_t             op;

    assign full = (cnt_reg == CNT_W'(FREE_RUNS));
    always_comb
    begin
        op      = op_in;
        op.push = op_in.push & ~full;
    end
    assign hit_w[0] = 1'b0;
    assign head_val = val_w[0];
    assign head_vld = vld_w[0];

    for (genvar i = 0; i < FREE_RUNS; i++)
    begin : g_cell
        logic [IDX_W-1:0] pv;
        logic             pvl;
        logic [IDX_W-1:0] nv;
        logic             nvl;
        if (i == 0)
        begin : g_first
            assign pv  = key;
            assign pvl = 1'b1;
        end
        else
        begin : g_mid
            assign pv  = val_w[i-1];
            assign pvl = vld_w[i-1];
        end
        if (i == FREE_RUNS - 1)
        begin : g_last
            assign nv  = val_w[0];
            assign nvl = op.rotate & vld_w[0];
        end
        else
        begin : g_inner
            assign nv  = val_w[i+1];
            assign nvl = vld_w[i+1];
        end
        fbfa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op),
            .key      (key),
            .prev_val (pv),
            .prev_vld (pvl),
            .nxt_val  (nv),
            .nxt_vld  (nvl),
            .hit_in   (hit_w[i]),
            .val      (val_w[i]),
            .vld      (vld_w[i]),
            .hit_out  (hit_w[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (op.push)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (op.remove && hit_w[FREE_RUNS])
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ sv/best_fit_block_allocator.sv @@
// Best-fit block allocator: sequencer, run tables and free-list chain.
//
// channel  dir  handshake                     payload
// command  in   start high while busy low     cmd (cmd_t)
// result   out  done high for one cycle       result (result_t)
// config   in   APB write, pready always high heap_limit at address 0
//
// Allocate: one full rotation of the free-list chain, then S_ASEL and S_ADEC.
// Free: walks runs from the heap bottom to the freed run, then merges free neighbours.
// Trim: checked in S_TCHK. Bad requests caught on accept never leave S_IDLE.
// Reset clears the list and run table valid bits, sets the heap bottom to TOP at once.
// The result is shown for one cycle; the next command may be accepted in that cycle.
module best_fit_block_allocator
    import fbfa_pkg::*;
#(
    parameter int FREE_RUNS   = 32,
    parameter int BLOCK_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SH    = $clog2(BLOCK_BYTES);
    localparam int SC_W  = $clog2(FREE_RUNS + 1);
    localparam logic [NEED_W-1:0] BB_M1 = NEED_W'(BLOCK_BYTES - 1);
    localparam logic [IDX_W-1:0]  TOP   = IDX_W'(BLOCKS - 1);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_ASCAN = 15'b000000000000010,
        S_ASEL  = 15'b000000000000100,
        S_ADEC  = 15'b000000000001000,
        S_ASPL  = 15'b000000000010000,
        S_ASET  = 15'b000000000100000,
        S_AGROW = 15'b000000001000000,
        S_FRD   = 15'b000000010000000,
        S_FCHK  = 15'b000000100000000,
        S_FRDL  = 15'b000001000000000,
        S_FRDU  = 15'b000010000000000,
        S_FDEC  = 15'b000100000000000,
        S_FMRG  = 15'b001000000000000,
        S_TCHK  = 15'b010000000000000,
        S_SPARE = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  limit_reg;
    logic [IDX_W-1:0]  bot_reg, bot_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0]  blk_reg, blk_next;
    logic [SC_W-1:0]   sc_reg, sc_next;
    logic              pv_reg;
    logic [IDX_W-1:0]  ps_reg;
    logic              found_reg, found_next;
    logic              exact_reg, exact_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [LEN_W-1:0]  bestn_reg, bestn_next;
    logic [IDX_W:0]    iw_reg, iw_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              lower_reg, lower_next;
    logic [IDX_W-1:0]  lstart_reg, lstart_next;
    logic [LEN_W:0]    nxt_reg, nxt_next;
    logic [LEN_W-1:0]  usz_reg, usz_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  start_reg, start_next;

    logic [LEN_W-1:0]  rl_mem  [BLOCKS];
    logic [LEN_W-1:0]  frs_mem [BLOCKS];
    logic [IDX_W-1:0]  rh_mem  [BLOCKS];
    logic [BLOCKS-1:0] rlv_reg;
    logic [BLOCKS-1:0] rhv_reg;
    logic [LEN_W-1:0]  rl_rd, frs_q;
    logic [IDX_W-1:0]  rh_q;
    logic              rlv_rd_reg, top_rd_reg;
    logic [LEN_W-1:0]  rl_q;

    logic [IDX_W-1:0]  ra;
    logic              rl_we, frs_we, rh_we, rhv_set, rhv_clr;
    logic [IDX_W-1:0]  rl_wa, frs_wa, rh_wa, rhv_sa, rhv_ca;
    logic [LEN_W-1:0]  rl_wd, frs_wd;
    logic [IDX_W-1:0]  rh_wd;

    lop_t              lop;
    logic [IDX_W-1:0]  lkey;
    logic [IDX_W-1:0]  head_val;
    logic              head_vld;
    logic              list_full;

    logic [NEED_W-1:0]   cmd_need;
    logic [NEED_W-1:0]   n_ext;
    logic [LEN_W-1:0]    walk_l;
    logic [IDX_W+1:0]    walk_sum;
    logic signed [NEED_W+1:0] grow_real;
    logic signed [NEED_W+1:0] grow_new;
    logic [LEN_W+1:0]    mtotal;
    logic [LEN_W+1:0]    mend;
    logic [IDX_W:0]      fit_end;

    assign cmd_need = (NEED_W'(cmd.size_bytes) + BB_M1) >> SH;
    assign rl_q     = rlv_rd_reg ? rl_rd : (top_rd_reg ? LEN_W'(1) : '0);
    assign n_ext    = NEED_W'(frs_q);
    assign walk_l   = (rl_q != '0) ? rl_q : frs_q;
    assign walk_sum = (IDX_W+2)'(iw_reg) + (IDX_W+2)'(walk_l);
    assign grow_real = $signed({2'b00, need_reg})
                     - $signed((NEED_W+2)'((rl_q == '0) ? frs_q : '0));
    assign grow_new  = $signed((NEED_W+2)'(bot_reg)) - grow_real;
    assign mtotal    = (LEN_W+2)'(lower_reg ? frs_q : '0) + (LEN_W+2)'(len_reg)
                     + (LEN_W+2)'(usz_reg);
    assign mend      = (LEN_W+2)'(lower_reg ? lstart_reg : blk_reg) + mtotal;
    assign fit_end   = (IDX_W+1)'(best_reg) + (IDX_W+1)'(bestn_reg);

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign pready = 1'b1;
    assign prdata = {{(32-IDX_W){1'b0}}, limit_reg};
    always_comb
    begin
        result.status      = status_reg;
        result.start_index = start_reg;
        result.heap_bottom = bot_reg;
    end

    fbfa_list #(.FREE_RUNS(FREE_RUNS)) u_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_in    (lop),
        .key      (lkey),
        .head_val (head_val),
        .head_vld (head_vld),
        .full     (list_full)
    );

    always_comb
    begin
        case (state_reg)
            S_ASCAN: ra = head_val;
            S_FRD:   ra = iw_reg[IDX_W-1:0];
            S_FRDL:  ra = blk_reg - 1'b1;
            S_FRDU:  ra = blk_reg + len_reg[IDX_W-1:0];
            S_FDEC:  ra = lower_reg ? lstart_reg : blk_reg;
            default: ra = bot_reg;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        bot_next    = bot_reg;
        need_next   = need_reg;
        blk_next    = blk_reg;
        sc_next     = sc_reg;
        found_next  = found_reg;
        exact_next  = exact_reg;
        best_next   = best_reg;
        bestn_next  = bestn_reg;
        iw_next     = iw_reg;
        len_next    = len_reg;
        lower_next  = lower_reg;
        lstart_next = lstart_reg;
        nxt_next    = nxt_reg;
        usz_next    = usz_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        start_next  = start_reg;
        lop         = '0;
        lkey        = '0;
        rl_we = 1'b0; rl_wa = '0; rl_wd = '0;
        frs_we = 1'b0; frs_wa = '0; frs_wd = '0;
        rh_we = 1'b0; rh_wa = '0; rh_wd = '0;
        rhv_set = 1'b0; rhv_sa = '0;
        rhv_clr = 1'b0; rhv_ca = '0;

        if ((state_reg == S_ASCAN && sc_reg != '0) || state_reg == S_ASEL)
        begin
            if (pv_reg && !exact_reg && (32'(ps_reg) < BLOCKS))
            begin
                if (n_ext == need_reg)
                begin
                    best_next  = ps_reg;
                    bestn_next = frs_q;
                    found_next = 1'b1;
                    exact_next = 1'b1;
                end
                else if (n_ext > need_reg && (!found_reg || frs_q < bestn_reg))
                begin
                    best_next  = ps_reg;
                    bestn_next = frs_q;
                    found_next = 1'b1;
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    need_next   = cmd_need;
                    blk_next    = cmd.block_index;
                    iw_next     = (IDX_W+1)'(bot_reg);
                    start_next  = '0;
                    case (cmd.action)
                        ACT_ALLOC:
                        begin
                            if (cmd_need == '0)
                            begin
                                status_next = ST_BAD;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                sc_next    = '0;
                                found_next = 1'b0;
                                exact_next = 1'b0;
                                state_next = S_ASCAN;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (cmd.block_index < bot_reg)
                            begin
                                status_next = ST_BAD;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FCHK;
                            end
                        end
                        ACT_TRIM: state_next = S_TCHK;
                        default:
                        begin
                            status_next = ST_BAD;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_ASCAN:
            begin
                lop.rotate = 1'b1;
                sc_next    = sc_reg + 1'b1;
                if (sc_reg == SC_W'(FREE_RUNS - 1))
                begin
                    state_next = S_ASEL;
                end
            end
            S_ASEL: state_next = S_ADEC;
            S_ADEC:
            begin
                if (found_reg)
                begin
                    if (32'(fit_end) > BLOCKS)
                    begin
                        status_next = ST_NOMEM;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        lop.remove = 1'b1;
                        lkey       = best_reg;
                        state_next = S_ASPL;
                    end
                end
                else
                begin
                    state_next = S_AGROW;
                end
            end
            S_ASPL:
            begin
                if (NEED_W'(bestn_reg) > need_reg)
                begin
                    lop.push = 1'b1;
                    lkey     = best_reg + need_reg[IDX_W-1:0];
                    frs_we   = 1'b1;
                    frs_wa   = lkey;
                    frs_wd   = bestn_reg - need_reg[LEN_W-1:0];
                    rl_we    = 1'b1;
                    rl_wa    = lkey;
                    rl_wd    = '0;
                    rh_we    = 1'b1;
                    rh_wa    = fit_end[IDX_W-1:0] - 1'b1;
                    rh_wd    = lkey;
                    rhv_set  = 1'b1;
                    rhv_sa   = rh_wa;
                end
                state_next = S_ASET;
            end
            S_ASET:
            begin
                rl_we       = 1'b1;
                rl_wa       = best_reg;
                rl_wd       = need_reg[LEN_W-1:0];
                rhv_clr     = 1'b1;
                rhv_ca      = best_reg + need_reg[IDX_W-1:0] - 1'b1;
                status_next = ST_OK;
                start_next  = best_reg;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_AGROW:
            begin
                if (grow_real <= 0 || grow_new < 0
                    || grow_new < $signed((NEED_W+2)'(limit_reg)))
                begin
                    status_next = ST_NOMEM;
                end
                else
                begin
                    if (rl_q == '0)
                    begin
                        lop.remove = 1'b1;
                        lkey       = bot_reg;
                    end
                    bot_next    = grow_new[IDX_W-1:0];
                    rl_we       = 1'b1;
                    rl_wa       = bot_next;
                    rl_wd       = need_reg[LEN_W-1:0];
                    rhv_clr     = 1'b1;
                    rhv_ca      = bot_next + need_reg[IDX_W-1:0] - 1'b1;
                    status_next = ST_OK;
                    start_next  = bot_next;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_FRD: state_next = S_FCHK;
            S_FCHK:
            begin
                state_next = S_IDLE;
                if (iw_reg == (IDX_W+1)'(blk_reg))
                begin
                    if (rl_q != '0
                        && (32'(blk_reg) + 32'(rl_q)) <= BLOCKS)
                    begin
                        len_next   = rl_q;
                        state_next = S_FRDL;
                    end
                    else
                    begin
                        status_next = ST_BAD;
                        done_next   = 1'b1;
                    end
                end
                else if (walk_l == '0 || 32'(walk_sum) >= BLOCKS)
                begin
                    status_next = ST_BAD;
                    done_next   = 1'b1;
                end
                else
                begin
                    iw_next    = walk_sum[IDX_W:0];
                    state_next = S_FRD;
                end
            end
            S_FRDL: state_next = S_FRDU;
            S_FRDU:
            begin
                lower_next  = (blk_reg > bot_reg) && rhv_reg[blk_reg - 1'b1]
                            && (rh_q < blk_reg);
                lstart_next = rh_q;
                nxt_next    = (LEN_W+1)'(blk_reg) + (LEN_W+1)'(len_reg);
                state_next  = S_FDEC;
            end
            S_FDEC:
            begin
                usz_next = '0;
                if (32'(nxt_reg) < BLOCKS && rl_q == '0)
                begin
                    usz_next   = frs_q;
                    lop.remove = 1'b1;
                    lkey       = nxt_reg[IDX_W-1:0];
                    state_next = S_FMRG;
                end
                else if (!lower_reg && list_full)
                begin
                    status_next = ST_NOMEM;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_FMRG;
                end
            end
            S_FMRG:
            begin
                if (!lower_reg)
                begin
                    lop.push = 1'b1;
                    lkey     = blk_reg;
                end
                if (mtotal == '0 || 32'(mend) > BLOCKS)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    frs_we      = 1'b1;
                    frs_wa      = lower_reg ? lstart_reg : blk_reg;
                    frs_wd      = mtotal[LEN_W-1:0];
                    rh_we       = 1'b1;
                    rh_wa       = mend[IDX_W-1:0] - 1'b1;
                    rh_wd       = frs_wa;
                    rhv_set     = 1'b1;
                    rhv_sa      = rh_wa;
                    rl_we       = 1'b1;
                    rl_wa       = blk_reg;
                    rl_wd       = '0;
                    status_next = ST_OK;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_TCHK:
            begin
                if (rl_q != '0 || frs_q == '0
                    || (32'(bot_reg) + 32'(frs_q)) >= BLOCKS)
                begin
                    status_next = ST_NOTRIM;
                end
                else
                begin
                    lop.remove  = 1'b1;
                    lkey        = bot_reg;
                    bot_next    = bot_reg + frs_q[IDX_W-1:0];
                    status_next = ST_OK;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            limit_reg  <= '0;
            bot_reg    <= TOP;
            done_reg   <= 1'b0;
            rlv_reg    <= '0;
            rhv_reg    <= '0;
            rlv_rd_reg <= 1'b0;
            top_rd_reg <= 1'b0;
            pv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bot_reg    <= bot_next;
            done_reg   <= done_next;
            rlv_rd_reg <= rlv_reg[ra];
            top_rd_reg <= (ra == TOP);
            pv_reg     <= (state_reg == S_ASCAN) & head_vld;
            if (psel && penable && pwrite && paddr[2] == REG_HEAP_LIMIT)
            begin
                limit_reg <= pwdata[IDX_W-1:0];
            end
            if (rl_we)
            begin
                rlv_reg[rl_wa] <= 1'b1;
            end
            if (rhv_set)
            begin
                rhv_reg[rhv_sa] <= 1'b1;
            end
            if (rhv_clr)
            begin
                rhv_reg[rhv_ca] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg   <= need_next;
        blk_reg    <= blk_next;
        sc_reg     <= sc_next;
        ps_reg     <= head_val;
        found_reg  <= found_next;
        exact_reg  <= exact_next;
        best_reg   <= best_next;
        bestn_reg  <= bestn_next;
        iw_reg     <= iw_next;
        len_reg    <= len_next;
        lower_reg  <= lower_next;
        lstart_reg <= lstart_next;
        nxt_reg    <= nxt_next;
        usz_reg    <= usz_next;
        status_reg <= status_next;
        start_reg  <= start_next;
        if (rl_we)
        begin
            rl_mem[rl_wa] <= rl_wd;
        end
        if (frs_we)
        begin
            frs_mem[frs_wa] <= frs_wd;
        end
        if (rh_we)
        begin
            rh_mem[rh_wa] <= rh_wd;
        end
        rl_rd <= rl_mem[ra];
        frs_q <= frs_mem[ra];
        rh_q  <= rh_mem[ra];
    end

endmodule

@@ tb/tb_best_fit_block_allocator.sv @@
// Self-checking testbench for the best-fit block allocator with a built-in allocation predictor.
`timescale 1ns / 100ps

module tb_best_fit_block_allocator;
    import fbfa_pkg::*;

    localparam int NBLK     = 64;
    localparam int NRUNS    = 32;
    localparam int BLK_SIZE = 4096;

    typedef struct {
        cmd_t c;
        bit   live_free;
    } op_item_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    best_fit_block_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [6:0] run_len   [NBLK];
    logic [6:0] free_len  [NBLK];
    logic [5:0] run_first [NBLK];
    logic       first_ok  [NBLK];
    logic [5:0] free_list [NRUNS];
    int         free_cnt;
    int         heap_bot;
    logic [5:0] limit_reg;

    op_item_t   op_queue[$];
    result_t    pending_results[$];
    logic [5:0] live_runs[$];
    int         gap_left;
    bit         no_idle;
    int         errors;
    int         mismatches;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void list_drop(input int blk);
        for (int i = 0; i < free_cnt; i++)
        begin
            if (free_list[i] == blk)
            begin
                for (int j = i; j < free_cnt - 1; j++)
                    free_list[j] = free_list[j + 1];
                free_cnt--;
                return;
            end
        end
    endfunction

    function automatic void list_add(input int blk);
        if (free_cnt >= NRUNS)
            return;
        for (int j = free_cnt; j > 0; j--)
            free_list[j] = free_list[j - 1];
        free_list[0] = blk[5:0];
        free_cnt++;
    endfunction

    function automatic logic [1:0] alloc_blocks(input int bytes, output int first);
        int need;
        int best;
        int total;
        int s;
        int n;
        int extra;
        int nstart;
        bit found;
        bit bot_free;
        need  = (bytes + BLK_SIZE - 1) / BLK_SIZE;
        best  = 0;
        found = 0;
        first = 0;
        if (need == 0)
            return ST_BAD;
        for (int i = 0; i < free_cnt; i++)
        begin
            s = free_list[i];
            n = free_len[s];
            if (n == need)
            begin
                best  = s;
                found = 1;
                break;
            end
            if (n > need && (!found || n < free_len[best]))
            begin
                best  = s;
                found = 1;
            end
        end
        if (found)
        begin
            total = free_len[best];
            if (best + total > NBLK)
                return ST_NOMEM;
            list_drop(best);
            if (total > need)
            begin
                list_add(best + need);
                free_len[best + need]       = 7'(total - need);
                run_len[best + need]        = '0;
                run_first[best + total - 1] = 6'(best + need);
                first_ok[best + total - 1]  = 1'b1;
            end
            run_len[best]              = 7'(need);
            first_ok[best + need - 1]  = 1'b0;
            first = best;
            return ST_OK;
        end
        bot_free = (run_len[heap_bot] == 0);
        extra    = need - (bot_free ? int'(free_len[heap_bot]) : 0);
        nstart   = heap_bot - extra;
        if (extra <= 0 || nstart < 0 || nstart < int'(limit_reg))
            return ST_NOMEM;
        if (bot_free)
            list_drop(heap_bot);
        heap_bot                     = nstart;
        run_len[nstart]              = 7'(need);
        first_ok[nstart + need - 1]  = 1'b0;
        first = nstart;
        return ST_OK;
    endfunction

    function automatic logic [1:0] free_blocks(input int b);
        int i;
        int l;
        int len;
        int nxt;
        int first;
        int total;
        int usz;
        bit ok;
        bit lower;
        bit upper;
        ok  = 0;
        usz = 0;
        if (b < heap_bot)
            return ST_BAD;
        i = heap_bot;
        while (i < NBLK)
        begin
            l = (run_len[i] != 0) ? int'(run_len[i]) : int'(free_len[i]);
            if (i == b)
            begin
                ok = (run_len[i] != 0);
                break;
            end
            if (l == 0)
                break;
            i += l;
        end
        if (!ok)
            return ST_BAD;
        len = run_len[b];
        if (b + len > NBLK)
            return ST_BAD;
        lower = (b > heap_bot) && first_ok[b - 1] && (run_first[b - 1] < b);
        nxt   = b + len;
        upper = (nxt < NBLK) && (run_len[nxt] == 0);
        if (!lower && !upper && free_cnt >= NRUNS)
            return ST_NOMEM;
        if (upper)
        begin
            usz = free_len[nxt];
            list_drop(nxt);
        end
        if (lower)
        begin
            first = run_first[b - 1];
            total = free_len[first] + len;
        end
        else
        begin
            first = b;
            total = len;
            list_add(b);
        end
        total += usz;
        if (total == 0 || first + total > NBLK)
            return ST_BAD;
        free_len[first]            = 7'(total);
        run_first[first + total - 1] = 6'(first);
        first_ok[first + total - 1]  = 1'b1;
        run_len[b]                 = '0;
        return ST_OK;
    endfunction

    function automatic logic [1:0] trim_bottom();
        int sz;
        if (run_len[heap_bot] != 0)
            return ST_NOTRIM;
        sz = free_len[heap_bot];
        if (sz == 0 || heap_bot + sz >= NBLK)
            return ST_NOTRIM;
        list_drop(heap_bot);
        heap_bot = heap_bot + sz;
        return ST_OK;
    endfunction

    function automatic result_t allocator_predict(input cmd_t c);
        result_t r;
        int first;
        first = 0;
        case (c.action)
            ACT_ALLOC: r.status = alloc_blocks(int'(c.size_bytes), first);
            ACT_FREE:  r.status = free_blocks(int'(c.block_index));
            ACT_TRIM:  r.status = trim_bottom();
            default:   r.status = ST_BAD;
        endcase
        if (r.status != ST_OK || c.action != ACT_ALLOC)
            first = 0;
        if (c.action == ACT_ALLOC && r.status == ST_OK)
            live_runs.push_back(6'(first));
        if (c.action == ACT_FREE && r.status == ST_OK)
        begin
            for (int i = 0; i < live_runs.size(); i++)
            begin
                if (live_runs[i] == c.block_index)
                begin
                    live_runs.delete(i);
                    break;
                end
            end
        end
        r.start_index = 6'(first);
        r.heap_bottom = 6'(heap_bot);
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        if (no_idle)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else
        begin
            op_item_t nxt;
            result_t  exp_r;
            bit       taken;
            taken = start && !busy;
            if (taken)
                pending_results.push_back(allocator_predict(cmd));
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result %p", $realtime, result);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result.status !== exp_r.status
                        || result.start_index !== exp_r.start_index
                        || result.heap_bottom !== exp_r.heap_bottom)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp %p got %p", $realtime, exp_r, result);
                    end
                end
            end
            if (!start || taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    nxt = op_queue.pop_front();
                    if (nxt.live_free && live_runs.size() > 0)
                        nxt.c.block_index = live_runs[$urandom_range(0, live_runs.size() - 1)];
                    cmd      <= nxt.c;
                    start    <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic add_op(input logic [1:0] act, input int bytes, input int blk, input bit live);
        op_item_t it;
        it.c.action      = act;
        it.c.size_bytes  = 19'(bytes);
        it.c.block_index = 6'(blk);
        it.live_free     = live;
        op_queue.push_back(it);
    endtask

    task automatic add_random_op();
        int p;
        int nb;
        p  = $urandom_range(0, 99);
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
        if (p < 45)
            add_op(ACT_ALLOC, $urandom_range((nb - 1) * BLK_SIZE + 1, nb * BLK_SIZE), 0, 0);
        else if (p < 85)
            add_op(ACT_FREE, $urandom_range(0, 524287), $urandom_range(0, 63), 1);
        else if (p < 92)
            add_op(ACT_TRIM, $urandom_range(0, 524287), $urandom_range(0, 63), 0);
        else if (p < 95)
            add_op(ACT_FREE, 0, $urandom_range(0, 63), 0);
        else if (p < 97)
            add_op(2'd3, $urandom_range(0, 524287), $urandom_range(0, 63), 0);
        else if (p < 98)
            add_op(ACT_ALLOC, 0, $urandom_range(0, 63), 0);
        else
            add_op(ACT_ALLOC, $urandom_range(262144, 524287), $urandom_range(0, 63), 0);
    endtask

    task automatic drain();
        while (op_queue.size() > 0 || start || pending_results.size() > 0 || gap_left > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(input logic [5:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * REG_HEAP_LIMIT);
        pwdata  <= {26'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        limit_reg = value;
    endtask

    initial
    begin
        logic [5:0] limits[6];
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        errors     = 0;
        mismatches = 0;
        no_idle    = 0;
        for (int i = 0; i < NBLK; i++)
        begin
            run_len[i]  = '0;
            free_len[i] = '0;
            run_first[i] = '0;
            first_ok[i] = 1'b0;
        end
        for (int i = 0; i < NRUNS; i++)
            free_list[i] = '0;
        run_len[NBLK - 1] = 7'd1;
        free_cnt  = 0;
        heap_bot  = NBLK - 1;
        limit_reg = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_limit(6'd0);

        add_op(ACT_ALLOC, 0, 0, 0);
        add_op(ACT_TRIM, 0, 0, 0);
        add_op(ACT_ALLOC, 1, 0, 0);
        add_op(ACT_ALLOC, 4096, 63, 0);
        add_op(ACT_ALLOC, 4097, 0, 0);
        add_op(ACT_ALLOC, 262144, 0, 0);
        add_op(ACT_ALLOC, 524287, 63, 0);
        add_op(ACT_FREE, 0, 0, 0);
        add_op(ACT_FREE, 0, 63, 0);
        add_op(ACT_FREE, 0, 62, 0);
        add_op(ACT_FREE, 0, 61, 0);
        add_op(ACT_ALLOC, 8192, 0, 0);
        add_op(ACT_ALLOC, 4096, 0, 0);
        add_op(ACT_FREE, 0, 59, 0);
        add_op(ACT_TRIM, 0, 0, 0);
        add_op(2'd3, 524287, 63, 0);
        add_op(ACT_ALLOC, 12288, 0, 0);
        add_op(ACT_FREE, 0, 0, 1);
        add_op(ACT_FREE, 0, 0, 1);
        add_op(ACT_TRIM, 0, 0, 0);
        drain();

        limits[0] = 6'd63;
        limits[1] = 6'd0;
        limits[2] = 6'd40;
        limits[3] = 6'($urandom_range(0, 63));
        limits[4] = 6'd20;
        limits[5] = 6'd0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_limit(limits[ph]);
            no_idle = (ph == 2);
            for (int k = 0; k < 122; k++)
                add_random_op();
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
sv/fbfa_pkg.sv
sv/fbfa_cell.sv
sv/fbfa_list.sv
sv/best_fit_block_allocator.sv
tb/tb_best_fit_block_allocator.sv
